@@ hw/rtl/phsp_pkg.sv @@
package phsp_pkg;

  // field sizes of the fixed-length header parts
  localparam int unsigned ID_BYTES   = 16;
  localparam int unsigned IPV4_BYTES = 4;
  localparam int unsigned IPV6_BYTES = 16;

  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IW-1:0] REG_RESPONSE_MODE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_EXPECTED_VERSION = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CODE_IPV4        = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CODE_DOMAIN      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CODE_IPV6        = 3'd4;

  // byte kind tags
  localparam logic [3:0] KIND_VERSION   = 4'd0;
  localparam logic [3:0] KIND_ID        = 4'd1;
  localparam logic [3:0] KIND_ADDON_LEN = 4'd2;
  localparam logic [3:0] KIND_ADDON     = 4'd3;
  localparam logic [3:0] KIND_COMMAND   = 4'd4;
  localparam logic [3:0] KIND_PORT_HI   = 4'd5;
  localparam logic [3:0] KIND_PORT_LO   = 4'd6;
  localparam logic [3:0] KIND_ADDR_TYPE = 4'd7;
  localparam logic [3:0] KIND_ADDR_LEN  = 4'd8;
  localparam logic [3:0] KIND_ADDR_BYTE = 4'd9;
  localparam logic [3:0] KIND_PAYLOAD   = 4'd10;
  localparam logic [3:0] KIND_DISCARD   = 4'd11;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_ATYPE   = 2'd2;

  // parser phase, one-hot
  typedef enum logic [12:0] {
    PH_VER       = 13'h0001,
    PH_ID        = 13'h0002,
    PH_ADDON_LEN = 13'h0004,
    PH_ADDON     = 13'h0008,
    PH_CMD       = 13'h0010,
    PH_PORT_HI   = 13'h0020,
    PH_PORT_LO   = 13'h0040,
    PH_ATYPE     = 13'h0080,
    PH_DOM_LEN   = 13'h0100,
    PH_ADDR      = 13'h0200,
    PH_PAYLOAD   = 13'h0400,
    PH_ERR_VER   = 13'h0800,
    PH_ERR_ATYPE = 13'h1000
  } phase_t;

  // configuration register set
  typedef struct packed {
    logic       response_mode;
    logic [7:0] expected_version;
    logic [7:0] code_ipv4;
    logic [7:0] code_domain;
    logic [7:0] code_ipv6;
  } cfg_t;

  // one input byte held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  // one tagged result
  typedef struct packed {
    logic [3:0]       byte_kind;
    logic [7:0]       byte_index;
    logic             header_done;
    logic [1:0]       error_code;
    logic [LEN_W-1:0] header_length;
    logic [7:0]       command_out;
    logic [15:0]      port_out;
    logic [7:0]       addr_type_out;
  } result_t;

endpackage

@@ hw/rtl/phsp_cfg_regs.sv @@
module phsp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [phsp_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [phsp_pkg::CFG_DW-1:0]   cfg_wdata,
  output phsp_pkg::cfg_t                cfg
);

  phsp_pkg::cfg_t cfg_r;
  phsp_pkg::cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        phsp_pkg::REG_RESPONSE_MODE:    cfg_nxt.response_mode    = cfg_wdata[0];
        phsp_pkg::REG_EXPECTED_VERSION: cfg_nxt.expected_version = cfg_wdata;
        phsp_pkg::REG_CODE_IPV4:        cfg_nxt.code_ipv4        = cfg_wdata;
        phsp_pkg::REG_CODE_DOMAIN:      cfg_nxt.code_domain      = cfg_wdata;
        phsp_pkg::REG_CODE_IPV6:        cfg_nxt.code_ipv6        = cfg_wdata;
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_mode    <= 1'b0;
      cfg_r.expected_version <= 8'd0;
      cfg_r.code_ipv4        <= 8'd1;
      cfg_r.code_domain      <= 8'd2;
      cfg_r.code_ipv6        <= 8'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/phsp_in_stage.sv @@
module phsp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                drain,
  input  phsp_pkg::in_item_t  item_in,
  output logic                valid,
  output phsp_pkg::in_item_t  item
);

  logic               valid_r;
  logic               valid_nxt;
  phsp_pkg::in_item_t item_r;

  // input register occupancy
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

@@ hw/rtl/phsp_core.sv @@
module phsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  phsp_pkg::cfg_t      cfg,
  input  phsp_pkg::in_item_t  item,
  output phsp_pkg::result_t   res
);

  localparam int unsigned LW = phsp_pkg::LEN_W;

  phsp_pkg::phase_t phase_r, phase_nxt, ph;
  logic [7:0]       fcount_r, fcount_nxt, fc;
  logic [7:0]       flen_r, flen_nxt, fl;
  logic [LW-1:0]    lcount_r, lcount_nxt, lc;
  logic [7:0]       cmd_r, cmd_nxt, cmd;
  logic [15:0]      port_r, port_nxt, port;
  logic [7:0]       atype_r, atype_nxt, atype;

  logic [8:0]       fc_inc;
  logic [LW-1:0]    lc_inc;
  logic [7:0]       fc_sat;
  logic [7:0]       b;
  logic [3:0]       kind;
  logic [7:0]       idx;
  logic [1:0]       err;
  logic             done;
  logic             req_done;

  // frame start restarts the parser before this byte
  always_comb begin
    if (item.frame_start) begin
      ph    = phsp_pkg::PH_VER;
      fc    = 8'd0;
      fl    = 8'd0;
      lc    = '0;
      cmd   = 8'd0;
      port  = 16'd0;
      atype = 8'd0;
    end else begin
      ph    = phase_r;
      fc    = fcount_r;
      fl    = flen_r;
      lc    = lcount_r;
      cmd   = cmd_r;
      port  = port_r;
      atype = atype_r;
    end
  end

  assign b      = item.data_byte;
  assign fc_inc = {1'b0, fc} + 9'd1;
  assign lc_inc = lc + {{(LW-1){1'b0}}, 1'b1};
  assign fc_sat = (fc == 8'hFF) ? fc : fc_inc[7:0];

  // per-byte field decode and next state
  always_comb begin
    phase_nxt  = ph;
    fcount_nxt = fc;
    flen_nxt   = fl;
    lcount_nxt = lc;
    cmd_nxt    = cmd;
    port_nxt   = port;
    atype_nxt  = atype;
    kind       = phsp_pkg::KIND_DISCARD;
    idx        = 8'd0;
    err        = phsp_pkg::ERR_NONE;
    done       = 1'b0;
    case (ph)
      phsp_pkg::PH_VER: begin
        kind       = phsp_pkg::KIND_VERSION;
        lcount_nxt = {{(LW-1){1'b0}}, 1'b1};
        fcount_nxt = 8'd0;
        if (b != cfg.expected_version) begin
          err       = phsp_pkg::ERR_VERSION;
          phase_nxt = phsp_pkg::PH_ERR_VER;
        end else if (cfg.response_mode) begin
          phase_nxt = phsp_pkg::PH_ADDON_LEN;
        end else begin
          phase_nxt = phsp_pkg::PH_ID;
        end
      end
      phsp_pkg::PH_ID: begin
        kind       = phsp_pkg::KIND_ID;
        idx        = fc;
        lcount_nxt = lc_inc;
        if (fc_inc >= 9'(phsp_pkg::ID_BYTES)) begin
          fcount_nxt = 8'd0;
          phase_nxt  = phsp_pkg::PH_ADDON_LEN;
        end else begin
          fcount_nxt = fc_inc[7:0];
        end
      end
      phsp_pkg::PH_ADDON_LEN: begin
        kind       = phsp_pkg::KIND_ADDON_LEN;
        lcount_nxt = lc_inc;
        flen_nxt   = b;
        fcount_nxt = 8'd0;
        if (b != 8'd0) begin
          phase_nxt = phsp_pkg::PH_ADDON;
        end else if (cfg.response_mode) begin
          done = 1'b1;
        end else begin
          phase_nxt = phsp_pkg::PH_CMD;
        end
      end
      phsp_pkg::PH_ADDON: begin
        kind       = phsp_pkg::KIND_ADDON;
        idx        = fc;
        lcount_nxt = lc_inc;
        if (fc_inc >= {1'b0, fl}) begin
          fcount_nxt = 8'd0;
          if (cfg.response_mode) begin
            done = 1'b1;
          end else begin
            phase_nxt = phsp_pkg::PH_CMD;
          end
        end else begin
          fcount_nxt = fc_inc[7:0];
        end
      end
      phsp_pkg::PH_CMD: begin
        kind       = phsp_pkg::KIND_COMMAND;
        lcount_nxt = lc_inc;
        cmd_nxt    = b;
        phase_nxt  = phsp_pkg::PH_PORT_HI;
      end
      phsp_pkg::PH_PORT_HI: begin
        kind       = phsp_pkg::KIND_PORT_HI;
        lcount_nxt = lc_inc;
        port_nxt   = {b, 8'h00};
        phase_nxt  = phsp_pkg::PH_PORT_LO;
      end
      phsp_pkg::PH_PORT_LO: begin
        kind       = phsp_pkg::KIND_PORT_LO;
        lcount_nxt = lc_inc;
        port_nxt   = {port[15:8], b};
        phase_nxt  = phsp_pkg::PH_ATYPE;
      end
      phsp_pkg::PH_ATYPE: begin
        kind       = phsp_pkg::KIND_ADDR_TYPE;
        lcount_nxt = lc_inc;
        atype_nxt  = b;
        fcount_nxt = 8'd0;
        // ipv4 wins over domain, domain over ipv6
        if (b == cfg.code_ipv4) begin
          flen_nxt  = 8'(phsp_pkg::IPV4_BYTES);
          phase_nxt = phsp_pkg::PH_ADDR;
        end else if (b == cfg.code_domain) begin
          phase_nxt = phsp_pkg::PH_DOM_LEN;
        end else if (b == cfg.code_ipv6) begin
          flen_nxt  = 8'(phsp_pkg::IPV6_BYTES);
          phase_nxt = phsp_pkg::PH_ADDR;
        end else begin
          err       = phsp_pkg::ERR_ATYPE;
          phase_nxt = phsp_pkg::PH_ERR_ATYPE;
        end
      end
      phsp_pkg::PH_DOM_LEN: begin
        kind       = phsp_pkg::KIND_ADDR_LEN;
        lcount_nxt = lc_inc;
        flen_nxt   = b;
        fcount_nxt = 8'd0;
        if (b == 8'd0) begin
          done = 1'b1;
        end else begin
          phase_nxt = phsp_pkg::PH_ADDR;
        end
      end
      phsp_pkg::PH_ADDR: begin
        kind       = phsp_pkg::KIND_ADDR_BYTE;
        idx        = fc;
        lcount_nxt = lc_inc;
        fcount_nxt = fc_inc[7:0];
        if (fc_inc >= {1'b0, fl}) begin
          done = 1'b1;
        end
      end
      phsp_pkg::PH_PAYLOAD: begin
        kind       = phsp_pkg::KIND_PAYLOAD;
        idx        = fc;
        fcount_nxt = fc_sat;
      end
      phsp_pkg::PH_ERR_VER: begin
        kind       = phsp_pkg::KIND_DISCARD;
        idx        = fc;
        fcount_nxt = fc_sat;
        err        = phsp_pkg::ERR_VERSION;
      end
      phsp_pkg::PH_ERR_ATYPE: begin
        kind       = phsp_pkg::KIND_DISCARD;
        idx        = fc;
        fcount_nxt = fc_sat;
        err        = phsp_pkg::ERR_ATYPE;
      end
      default: begin
        kind       = phsp_pkg::KIND_DISCARD;
        idx        = fc;
        fcount_nxt = fc_sat;
      end
    endcase
    // header complete: switch to payload
    if (done) begin
      phase_nxt  = phsp_pkg::PH_PAYLOAD;
      fcount_nxt = 8'd0;
    end
  end

  // parser state, advanced once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= phsp_pkg::PH_VER;
      fcount_r <= 8'd0;
      flen_r   <= 8'd0;
      lcount_r <= '0;
      cmd_r    <= 8'd0;
      port_r   <= 16'd0;
      atype_r  <= 8'd0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fcount_r <= fcount_nxt;
      flen_r   <= flen_nxt;
      lcount_r <= lcount_nxt;
      cmd_r    <= cmd_nxt;
      port_r   <= port_nxt;
      atype_r  <= atype_nxt;
    end
  end

  // result fields
  assign req_done          = done && !cfg.response_mode;
  assign res.byte_kind     = kind;
  assign res.byte_index    = idx;
  assign res.header_done   = done;
  assign res.error_code    = err;
  assign res.header_length = done ? lcount_nxt : '0;
  assign res.command_out   = req_done ? cmd_nxt : 8'd0;
  assign res.port_out      = req_done ? port_nxt : 16'd0;
  assign res.addr_type_out = req_done ? atype_nxt : 8'd0;

endmodule

@@ hw/rtl/phsp_out_stage.sv @@
module phsp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  phsp_pkg::result_t  res_in,
  input  logic               out_ready,
  output logic               can_load,
  output logic               out_valid,
  output phsp_pkg::result_t  res
);

  logic              valid_r;
  logic              valid_nxt;
  phsp_pkg::result_t res_r;

  // result register occupancy
  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

@@ hw/rtl/proxy_header_stream_parser.sv @@
// flow: an accepted byte is held in the input register, then its result is
// registered in the result register, which drives out_tvalid
// throughput: one byte per cycle; in_tready drops only while both the input
// and the result register are full and out_tready is low
// reset: synchronous, active low; parser expects a version byte, counters
// and captured fields clear, registers take their reset values
module proxy_header_stream_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // data_byte
  input  logic                         in_tuser,   // frame_start
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // byte_index[7:0], header_length[17:8], command_out[25:18],
  // port_out[41:26], addr_type_out[49:42], zero fill[55:50]
  output logic [55:0]                  out_tdata,
  output logic [5:0]                   out_tuser,  // byte_kind[3:0], error_code[5:4]
  output logic                         out_tlast,  // header_done
  // configuration
  input  logic                         cfg_we,
  input  logic [phsp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [phsp_pkg::CFG_DW-1:0]  cfg_wdata
);

  phsp_pkg::cfg_t     cfg;
  phsp_pkg::in_item_t in_item;
  phsp_pkg::in_item_t held_item;
  phsp_pkg::result_t  core_res;
  phsp_pkg::result_t  out_res;
  logic               held_valid;
  logic               can_load;
  logic               advance;
  logic               in_take;

  assign in_item.data_byte   = in_tdata;
  assign in_item.frame_start = in_tuser;

  // a held byte moves on whenever the result register can take it
  assign advance   = held_valid && can_load;
  assign in_tready = !held_valid || advance;
  assign in_take   = in_tvalid && in_tready;

  phsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  phsp_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_take),
    .drain   (advance),
    .item_in (in_item),
    .valid   (held_valid),
    .item    (held_item)
  );

  phsp_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .cfg   (cfg),
    .item  (held_item),
    .res   (core_res)
  );

  phsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (core_res),
    .out_ready (out_tready),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .res       (out_res)
  );

  // result packing
  assign out_tdata = {6'd0, out_res.addr_type_out, out_res.port_out, out_res.command_out,
                      out_res.header_length, out_res.byte_index};
  assign out_tuser = {out_res.error_code, out_res.byte_kind};
  assign out_tlast = out_res.header_done;

endmodule

@@ hw/rtl/phsp_checker.sv @@
module phsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [5:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a completed header carries a nonzero length
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[17:8] != 10'd0)
    else $error("header done with zero length");

  // header summary fields are zero on other bytes
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[55:8] == 48'd0)
    else $error("summary fields set without header done");

  // an error byte never completes a header
  a_err_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[5:4] != phsp_pkg::ERR_NONE |-> !out_tlast)
    else $error("error byte flagged as header done");

endmodule

bind proxy_header_stream_parser phsp_checker u_phsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
